### src/assert_macros.svh
// Assertion macros for the gyro turn tick timer.
// Each macro checks a property on the rising edge of clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GTTT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gttt: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define GTTT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gttt: next-cycle check failed");

`endif

### src/gttt_pkg.sv
// Shared types and constants for the gyro turn tick timer.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none

package gttt_pkg;

  // Field widths fixed by the item format.
  localparam int SAMPLE_W = 16;
  localparam int ANGLE_W  = 9;
  localparam int TICK_W   = 16;
  localparam int AVG_W    = 16;

  // Configuration port.
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;
  localparam logic REG_INIT_TARGET = 1'b0;

  // Default parameter values.
  localparam int DEF_SETTLE_TICKS     = 8;
  localparam int DEF_MEASURE_TICKS    = 30;
  localparam int DEF_TICKS_PER_SECOND = 60;

  // Gyro scale 16.3835 as a ratio of integers.
  localparam int RATE_SCALE_NUM = 163835;
  localparam int RATE_SCALE_DEN = 10000;
  localparam int NUM_SCALE_W    = 18;
  localparam int DEN_SCALE_W    = 14;

  // Largest average magnitude times the denominator scale sets the divisor width.
  localparam int AVG_MAX = 2 ** (SAMPLE_W - 1);
  localparam int DEN_W   = $clog2(AVG_MAX * RATE_SCALE_DEN + 1);

  localparam logic [TICK_W-1:0] INIT_TARGET_RESET = 16'd360;
  localparam logic [TICK_W-1:0] TARGET_SAT        = 16'hFFFF;

  // Operation codes of an input transaction.
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic step;
    logic avg_start;
    logic avg_latch;
    logic mul1;
    logic mul2;
    logic div_start;
    logic target_latch;
    logic sat_target;
    logic check;
    logic emit;
  } gttt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_tick;
    logic running;
    logic measure_hit;
    logic window_zero;
    logic avg_zero;
    logic div_done;
  } gttt_status_t;

endpackage

`default_nettype wire

### src/gyro_turn_tick_timer_unit.sv
// Top level of the gyro turn tick timer: configuration register port and assertions.
// Depends on gttt_pkg, gttt_ctrl, gttt_dpath (with gttt_div) and assert_macros.svh.
//
// A start transaction arms a turn with its angle, clears the count and loads the target
// from the initial target register; each tick transaction advances the count while a turn
// runs, sums sample magnitudes over the settle-to-measure window and, at the measure tick,
// replaces the target with TICKS_PER_SECOND*angle*16.3835 over the window average, then
// stops the turn once the count reaches the target. One transaction is worked on at a
// time. At the measure tick the shared one-bit-per-cycle divider, W bits wide, forms
// first the average and then the target (W is 33 at default parameters). The next
// transaction is accepted while a result still waits in the output register. The
// register map holds one word, the initial target at address 0.
`default_nettype none

`include "assert_macros.svh"

module gyro_turn_tick_timer_unit #(
  parameter int SETTLE_TICKS     = gttt_pkg::DEF_SETTLE_TICKS,
  parameter int MEASURE_TICKS    = gttt_pkg::DEF_MEASURE_TICKS,
  parameter int TICKS_PER_SECOND = gttt_pkg::DEF_TICKS_PER_SECOND
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Input channel.
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 in_op,
  input  wire logic [gttt_pkg::ANGLE_W-1:0]         in_turn_angle,
  input  wire logic signed [gttt_pkg::SAMPLE_W-1:0] in_rate_sample,
  // Result channel.
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      out_done_res,
  output logic                                      out_stop_pulse,
  output logic [gttt_pkg::TICK_W-1:0]               out_tick_count,
  output logic [gttt_pkg::TICK_W-1:0]               out_target_ticks,
  // Configuration port.
  input  wire logic                                 cfg_psel,
  input  wire logic                                 cfg_penable,
  input  wire logic                                 cfg_pwrite,
  input  wire logic [gttt_pkg::APB_AW-1:0]          cfg_paddr,
  input  wire logic [gttt_pkg::APB_DW-1:0]          cfg_pwdata,
  output logic [gttt_pkg::APB_DW-1:0]               cfg_prdata,
  output logic                                      cfg_pready
);

  gttt_pkg::gttt_cmd_t    cmd;
  gttt_pkg::gttt_status_t status;
  logic                   reg_sel;
  logic                   cfg_we;
  logic [gttt_pkg::TICK_W-1:0] cfg_target;

  // Register decode: the word index sits above the byte offset.
  assign reg_sel    = (cfg_paddr[2] == gttt_pkg::REG_INIT_TARGET);
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite & reg_sel;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_sel ? gttt_pkg::APB_DW'(cfg_target) : '0;

  gttt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  gttt_dpath #(
    .SETTLE_TICKS     (SETTLE_TICKS),
    .MEASURE_TICKS    (MEASURE_TICKS),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_op            (in_op),
    .in_turn_angle    (in_turn_angle),
    .in_rate_sample   (in_rate_sample),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_pwdata[gttt_pkg::TICK_W-1:0]),
    .cfg_target       (cfg_target),
    .cmd              (cmd),
    .status           (status),
    .out_done_res     (out_done_res),
    .out_stop_pulse   (out_stop_pulse),
    .out_tick_count   (out_tick_count),
    .out_target_ticks (out_target_ticks)
  );

  // A stop pulse only comes with a finished turn whose count reached its target.
  `GTTT_ASSERT_IMP(a_pulse_sets_done, out_valid && out_stop_pulse, out_done_res)
  `GTTT_ASSERT_IMP(a_pulse_at_target, out_valid && out_stop_pulse, out_tick_count >= out_target_ticks)
  // Only one transaction is worked on at a time.
  `GTTT_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)

endmodule

`default_nettype wire

### src/gttt_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing; instantiated by the datapath and shared by both divisions.
`default_nettype none

module gttt_div #(
  parameter int W = 33
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quotient
);

  localparam int CNT_W = $clog2(W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     quo_r, quo_nxt;
  logic [W-1:0]     div_r, div_nxt;
  logic [W:0]       rem_shift;
  logic [W:0]       diff;
  logic             q_bit;

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign rem_shift = {rem_r, quo_r[W-1]};
  assign diff      = rem_shift - {1'b0, div_r};
  assign q_bit     = ~diff[W];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(W);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = q_bit ? diff[W-1:0] : rem_shift[W-1:0];
      quo_nxt = {quo_r[W-2:0], q_bit};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

### src/gttt_dpath.sv
// Datapath of the gyro turn tick timer: turn state, rate sum, target math, result register.
// Depends on gttt_pkg and gttt_div; driven by commands from gttt_ctrl.
`default_nettype none

module gttt_dpath #(
  parameter int SETTLE_TICKS     = gttt_pkg::DEF_SETTLE_TICKS,
  parameter int MEASURE_TICKS    = gttt_pkg::DEF_MEASURE_TICKS,
  parameter int TICKS_PER_SECOND = gttt_pkg::DEF_TICKS_PER_SECOND
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_op,
  input  wire logic [gttt_pkg::ANGLE_W-1:0]        in_turn_angle,
  input  wire logic signed [gttt_pkg::SAMPLE_W-1:0] in_rate_sample,
  input  wire logic                                cfg_we,
  input  wire logic [gttt_pkg::TICK_W-1:0]         cfg_wdata,
  output logic [gttt_pkg::TICK_W-1:0]              cfg_target,
  input  wire gttt_pkg::gttt_cmd_t                 cmd,
  output gttt_pkg::gttt_status_t                   status,
  output logic                                     out_done_res,
  output logic                                     out_stop_pulse,
  output logic [gttt_pkg::TICK_W-1:0]              out_tick_count,
  output logic [gttt_pkg::TICK_W-1:0]              out_target_ticks
);

  localparam int TICK_W   = gttt_pkg::TICK_W;
  localparam int SAMPLE_W = gttt_pkg::SAMPLE_W;
  localparam int ANGLE_W  = gttt_pkg::ANGLE_W;
  localparam int AVG_W    = gttt_pkg::AVG_W;
  localparam int DEN_W    = gttt_pkg::DEN_W;
  localparam int NSC_W    = gttt_pkg::NUM_SCALE_W;
  localparam int DSC_W    = gttt_pkg::DEN_SCALE_W;

  localparam int WINDOW = (MEASURE_TICKS > SETTLE_TICKS) ? (MEASURE_TICKS - SETTLE_TICKS) : 0;
  localparam int SUM_W  = $clog2(((WINDOW > 0) ? WINDOW : 1) * gttt_pkg::AVG_MAX + 1);
  localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
  localparam int TA_W   = ANGLE_W + TPS_W;
  localparam int NUM_W  = TA_W + NSC_W;
  localparam int ND_W   = (NUM_W > DEN_W) ? NUM_W : DEN_W;
  localparam int DIV_W  = (ND_W > SUM_W) ? ND_W : SUM_W;

  localparam logic [TPS_W-1:0] TPS_C       = TPS_W'(TICKS_PER_SECOND);
  localparam logic [NSC_W-1:0] SCALE_NUM_C = NSC_W'(gttt_pkg::RATE_SCALE_NUM);
  localparam logic [DSC_W-1:0] SCALE_DEN_C = DSC_W'(gttt_pkg::RATE_SCALE_DEN);

  // Architectural turn state.
  logic [TICK_W-1:0]  init_target_r, init_target_nxt;
  logic [TICK_W-1:0]  ticks_r, ticks_nxt;
  logic [TICK_W-1:0]  target_r, target_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [ANGLE_W-1:0] angle_held_r, angle_held_nxt;
  logic               running_r, running_nxt;
  logic               finished_r, finished_nxt;
  logic               pulse_r, pulse_nxt;

  // Captured transaction and intermediate math.
  logic                 op_r;
  logic [ANGLE_W-1:0]   angle_in_r;
  logic [SAMPLE_W-1:0]  sample_r;
  logic [AVG_W-1:0]     avg_r;
  logic [TA_W-1:0]      ta_r;
  logic [DEN_W-1:0]     den_r;
  logic [NUM_W-1:0]     num_r;

  logic [TICK_W-1:0]      tick_inc;
  logic                   in_window;
  logic [SAMPLE_W-1:0]    sample_mag;
  logic [TA_W-1:0]        ta_prod;
  logic [AVG_W+DSC_W-1:0] den_prod;
  logic [NUM_W-1:0]       num_prod;
  logic                   div_go;
  logic [DIV_W-1:0]       div_dividend;
  logic [DIV_W-1:0]       div_divisor;
  logic                   div_done;
  logic [DIV_W-1:0]       div_quo;
  logic [TICK_W-1:0]      quo_sat;

  // Tick bookkeeping and sample magnitude.
  assign tick_inc   = ticks_r + TICK_W'(1);
  assign in_window  = (tick_inc >= TICK_W'(SETTLE_TICKS)) && (tick_inc < TICK_W'(MEASURE_TICKS));
  assign sample_mag = sample_r[SAMPLE_W-1] ? (~sample_r + SAMPLE_W'(1)) : sample_r;

  // Products for numerator and denominator of the target division.
  assign ta_prod  = angle_held_r * TPS_C;
  assign den_prod = avg_r * SCALE_DEN_C;
  assign num_prod = ta_r * SCALE_NUM_C;

  // Shared divider: sum over the window first, then numerator over denominator.
  assign div_go       = cmd.avg_start | cmd.div_start;
  assign div_dividend = cmd.div_start ? DIV_W'(num_r) : DIV_W'(sum_r);
  assign div_divisor  = cmd.div_start ? DIV_W'(den_r) : DIV_W'(WINDOW);

  gttt_div #(
    .W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // A quotient that does not fit in the tick width saturates.
  assign quo_sat = (|div_quo[DIV_W-1:TICK_W]) ? gttt_pkg::TARGET_SAT : div_quo[TICK_W-1:0];

  // Next turn state.
  always_comb begin
    init_target_nxt = cfg_we ? cfg_wdata : init_target_r;
    ticks_nxt       = ticks_r;
    target_nxt      = target_r;
    sum_nxt         = sum_r;
    angle_held_nxt  = angle_held_r;
    running_nxt     = running_r;
    finished_nxt    = finished_r;
    pulse_nxt       = pulse_r;
    if (cmd.step) begin
      pulse_nxt = 1'b0;
      if (op_r == gttt_pkg::OP_START) begin
        target_nxt     = init_target_r;
        angle_held_nxt = angle_in_r;
        ticks_nxt      = '0;
        sum_nxt        = '0;
        running_nxt    = 1'b1;
        finished_nxt   = 1'b0;
      end else if (running_r) begin
        ticks_nxt = tick_inc;
        if (in_window) begin
          sum_nxt = sum_r + SUM_W'(sample_mag);
        end
      end
    end
    if (cmd.sat_target) begin
      target_nxt = gttt_pkg::TARGET_SAT;
    end
    if (cmd.target_latch) begin
      target_nxt = quo_sat;
    end
    if (cmd.check && (ticks_r >= target_r)) begin
      running_nxt  = 1'b0;
      finished_nxt = 1'b1;
      pulse_nxt    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_target_r <= gttt_pkg::INIT_TARGET_RESET;
      ticks_r       <= '0;
      target_r      <= gttt_pkg::INIT_TARGET_RESET;
      sum_r         <= '0;
      angle_held_r  <= '0;
      running_r     <= 1'b0;
      finished_r    <= 1'b0;
      pulse_r       <= 1'b0;
    end else begin
      init_target_r <= init_target_nxt;
      ticks_r       <= ticks_nxt;
      target_r      <= target_nxt;
      sum_r         <= sum_nxt;
      angle_held_r  <= angle_held_nxt;
      running_r     <= running_nxt;
      finished_r    <= finished_nxt;
      pulse_r       <= pulse_nxt;
    end
  end

  // Transaction capture, intermediate products and the result register.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= in_op;
      angle_in_r <= in_turn_angle;
      sample_r   <= $unsigned(in_rate_sample);
    end
    if (cmd.avg_latch) begin
      avg_r <= div_quo[AVG_W-1:0];
    end
    if (cmd.mul1) begin
      ta_r  <= ta_prod;
      den_r <= den_prod[DEN_W-1:0];
    end
    if (cmd.mul2) begin
      num_r <= num_prod;
    end
    if (cmd.emit) begin
      out_done_res     <= finished_r;
      out_stop_pulse   <= pulse_r;
      out_tick_count   <= ticks_r;
      out_target_ticks <= target_r;
    end
  end

  // Status to the controller.
  always_comb begin
    status.op_tick     = (op_r == gttt_pkg::OP_TICK);
    status.running     = running_r;
    status.measure_hit = (tick_inc == TICK_W'(MEASURE_TICKS));
    status.window_zero = (WINDOW == 0);
    status.avg_zero    = (avg_r == '0);
    status.div_done    = div_done;
  end

  assign cfg_target = init_target_r;

endmodule

`default_nettype wire

### src/gttt_ctrl.sv
// Controller state machine of the gyro turn tick timer.
// Depends on gttt_pkg; sequences gttt_dpath through commands and reads its status.
`default_nettype none

module gttt_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output gttt_pkg::gttt_cmd_t         cmd,
  input  wire gttt_pkg::gttt_status_t status
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_STEP     = 10'b00_0000_0010,
    S_AVG      = 10'b00_0000_0100,
    S_AVG_WAIT = 10'b00_0000_1000,
    S_MUL1     = 10'b00_0001_0000,
    S_MUL2     = 10'b00_0010_0000,
    S_DIV      = 10'b00_0100_0000,
    S_DIV_WAIT = 10'b00_1000_0000,
    S_CHECK    = 10'b01_0000_0000,
    S_EMIT     = 10'b10_0000_0000
  } gttt_state_t;

  gttt_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  // The result register can take a new result when empty or being drained.
  assign out_free = ~out_valid_r | out_ready;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step = 1'b1;
        if (status.op_tick && status.running) begin
          state_nxt = status.measure_hit ? S_AVG : S_CHECK;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_AVG: begin
        if (status.window_zero) begin
          cmd.sat_target = 1'b1;
          state_nxt      = S_CHECK;
        end else begin
          cmd.avg_start = 1'b1;
          state_nxt     = S_AVG_WAIT;
        end
      end
      S_AVG_WAIT: begin
        if (status.div_done) begin
          cmd.avg_latch = 1'b1;
          state_nxt     = S_MUL1;
        end
      end
      S_MUL1: begin
        if (status.avg_zero) begin
          cmd.sat_target = 1'b1;
          state_nxt      = S_CHECK;
        end else begin
          cmd.mul1  = 1'b1;
          state_nxt = S_MUL2;
        end
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.target_latch = 1'b1;
          state_nxt        = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result valid flag: set on emit, cleared when the transaction is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for gyro_turn_tick_timer_unit: directed table, then random turns.
// Depends on gttt_pkg and the RTL of the block; checks every result against its own predictor or a typed result.
`default_nettype none

module testbench;
  import gttt_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASE_ITEMS  = 160;
  localparam int LONG_HOLD    = 300;
  localparam int END_LATENCY  = 100;
  localparam int SETTLE       = DEF_SETTLE_TICKS;
  localparam int MEASURE      = DEF_MEASURE_TICKS;
  localparam int TICK_RATE    = DEF_TICKS_PER_SECOND;
  localparam logic [APB_AW-1:0] INIT_TARGET_ADDR = APB_AW'(4 * REG_INIT_TARGET);

  // One result transaction as the block reports it.
  typedef struct packed {
    logic              done_res;
    logic              stop_pulse;
    logic [TICK_W-1:0] tick_count;
    logic [TICK_W-1:0] target_ticks;
  } turn_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  // A stimulus row: either an input transaction or a register write.
  typedef struct packed {
    row_kind_e           kind;
    logic                op;
    logic [ANGLE_W-1:0]  angle;
    logic [SAMPLE_W-1:0] sample;
    logic                pinned;
    turn_result_t        want;
    logic [TICK_W-1:0]   reg_value;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_op = OP_START;
  logic [ANGLE_W-1:0]  in_turn_angle = '0;
  logic [SAMPLE_W-1:0] in_rate_sample = '0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_done_res;
  logic              out_stop_pulse;
  logic [TICK_W-1:0] out_tick_count;
  logic [TICK_W-1:0] out_target_ticks;

  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [APB_AW-1:0] cfg_paddr = '0;
  logic [APB_DW-1:0] cfg_pwdata = '0;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // Predictor state, kept apart from the block.
  logic [TICK_W-1:0]  pred_ticks;
  logic [TICK_W-1:0]  pred_target;
  logic [31:0]        pred_rate_sum;
  logic [ANGLE_W-1:0] pred_angle;
  logic               pred_running;
  logic               pred_finished;
  logic [TICK_W-1:0]  init_target_shadow = INIT_TARGET_RESET;

  stim_row_t    offered_items[$];
  turn_result_t pending_results[$];
  stim_row_t    dir_table[$];

  int error_count = 0;
  int live_items = 0;
  int cycle_count = 0;
  bit no_idle = 1'b0;
  bit hold_off_req = 1'b0;

  gyro_turn_tick_timer_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_turn_angle    (in_turn_angle),
    .in_rate_sample   (in_rate_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_done_res     (out_done_res),
    .out_stop_pulse   (out_stop_pulse),
    .out_tick_count   (out_tick_count),
    .out_target_ticks (out_target_ticks),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  // Clock with a period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cycle counter that ends a run that hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report_mismatch(string field, int got_val, int want_val);
    $display("mismatch: %s got %0d, expected %0d", field, got_val, want_val);
    error_count++;
  endtask

  function automatic stim_row_t item_row(logic op, logic [ANGLE_W-1:0] angle,
                                         logic [SAMPLE_W-1:0] sample, logic pinned,
                                         turn_result_t want);
    stim_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.op = op;
    row.angle = angle;
    row.sample = sample;
    row.pinned = pinned;
    row.want = want;
    return row;
  endfunction

  function automatic stim_row_t reg_row(logic [TICK_W-1:0] value);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.reg_value = value;
    return row;
  endfunction

  // Target from the measured window: rate scale 16.3835 over the average magnitude.
  function automatic logic [TICK_W-1:0] measured_target(logic [ANGLE_W-1:0] angle,
                                                        logic [31:0] rate_sum);
    int window;
    logic [63:0] avg;
    logic [63:0] quot;
    window = (MEASURE > SETTLE) ? MEASURE - SETTLE : 0;
    if (window == 0) return TARGET_SAT;
    avg = 64'(rate_sum) / 64'(window);
    if (avg == 0) return TARGET_SAT;
    quot = (64'(TICK_RATE) * 64'(angle) * 64'(RATE_SCALE_NUM)) /
           (avg * 64'(RATE_SCALE_DEN));
    return (quot > 64'(TARGET_SAT)) ? TARGET_SAT : quot[TICK_W-1:0];
  endfunction

  // Advances the predicted turn by one input transaction.
  function automatic turn_result_t predict_turn(logic op, logic [ANGLE_W-1:0] angle,
                                                logic [SAMPLE_W-1:0] sample);
    turn_result_t res;
    logic [SAMPLE_W:0] mag;
    logic pulse;
    pulse = 1'b0;
    if (op == OP_START) begin
      pred_target = init_target_shadow;
      pred_angle = angle;
      pred_ticks = '0;
      pred_rate_sum = '0;
      pred_running = 1'b1;
      pred_finished = 1'b0;
    end else if (pred_running) begin
      pred_ticks = pred_ticks + 1'b1;
      if (pred_ticks >= SETTLE && pred_ticks < MEASURE) begin
        mag = sample[SAMPLE_W-1] ? ((SAMPLE_W+1)'(1) << SAMPLE_W) - {1'b0, sample}
                                 : {1'b0, sample};
        pred_rate_sum = pred_rate_sum + 32'(mag);
      end else if (pred_ticks == MEASURE) begin
        pred_target = measured_target(pred_angle, pred_rate_sum);
      end
      if (pred_ticks >= pred_target) begin
        pred_running = 1'b0;
        pred_finished = 1'b1;
        pulse = 1'b1;
      end
    end
    res.done_res = pred_finished;
    res.stop_pulse = pulse;
    res.tick_count = pred_ticks;
    res.target_ticks = pred_target;
    return res;
  endfunction

  // On each accepted input transaction, work out the result it must cause.
  always @(posedge clk) begin : input_monitor
    stim_row_t row;
    turn_result_t predicted;
    if (!rst_n) begin
      pred_ticks = '0;
      pred_target = init_target_shadow;
      pred_rate_sum = '0;
      pred_angle = '0;
      pred_running = 1'b0;
      pred_finished = 1'b0;
    end else if (in_valid && in_ready) begin
      row = offered_items.pop_front();
      if (in_op == OP_START || pred_running) live_items++;
      predicted = predict_turn(in_op, in_turn_angle, in_rate_sample);
      pending_results.push_back(row.pinned ? row.want : predicted);
    end
  end

  // Compare each accepted result transaction with the oldest pending one.
  always @(posedge clk) begin : result_check
    turn_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, tick_count", out_tick_count, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_done_res !== want.done_res)
          report_mismatch("done_res", out_done_res, want.done_res);
        if (out_stop_pulse !== want.stop_pulse)
          report_mismatch("stop_pulse", out_stop_pulse, want.stop_pulse);
        if (out_tick_count !== want.tick_count)
          report_mismatch("tick_count", out_tick_count, want.tick_count);
        if (out_target_ticks !== want.target_ticks)
          report_mismatch("target_ticks", out_target_ticks, want.target_ticks);
      end
    end
  end

  // Random gap length: mostly none or short, a few long.
  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result receiver: random stalls, and one long hold-off when asked.
  initial begin : result_sink
    int stall;
    while (!rst_n) @(posedge clk);
    @(posedge clk);
    forever begin
      stall = hold_off_req ? LONG_HOLD : pick_gap();
      hold_off_req = 1'b0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Offer one input transaction and hold it until accepted, then idle for a random gap that may be empty.
  task automatic offer_row(stim_row_t row);
    int gap;
    offered_items.push_back(row);
    in_valid <= 1'b1;
    in_op <= row.op;
    in_turn_angle <= row.angle;
    in_rate_sample <= row.sample;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic offer_random(logic op, logic [ANGLE_W-1:0] angle, logic [SAMPLE_W-1:0] sample);
    offer_row(item_row(op, angle, sample, 1'b0, '0));
  endtask

  // Wait until every offered transaction has produced its result.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (offered_items.size() != 0 || pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write, then a read back of the same register.
  task automatic write_init_target(logic [TICK_W-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= INIT_TARGET_ADDR;
    cfg_pwdata <= APB_DW'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    init_target_shadow = value;
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata[TICK_W-1:0] !== value)
      report_mismatch("initial_target_ticks read back", cfg_prdata[TICK_W-1:0], value);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // One well-formed turn: a start, then ticks whose samples follow one pattern.
  task automatic run_turn();
    int roll;
    int pattern;
    int len;
    int aim_target;
    int mag_aim;
    int mag;
    int tiny;
    logic [ANGLE_W-1:0] angle;
    logic [SAMPLE_W-1:0] sample;
    roll = $urandom_range(0, 99);
    if (roll < 10) angle = '0;
    else if (roll < 20) angle = ANGLE_W'($urandom_range(361, 511));
    else angle = ANGLE_W'($urandom_range(1, 360));
    pattern = $urandom_range(0, 4);
    // Aim the average so that the measured target lands a little past the measure tick.
    aim_target = $urandom_range(MEASURE + 1, MEASURE + 30);
    mag_aim = (983 * int'(angle)) / aim_target;
    if (mag_aim < 1) mag_aim = 1;
    if (mag_aim > 30000) mag_aim = 30000;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MEASURE - 1)
                                      : $urandom_range(MEASURE, MEASURE + 40);
    if (init_target_shadow < MEASURE)
      len = int'(init_target_shadow) + $urandom_range(0, 3);
    offer_random(OP_START, angle, SAMPLE_W'($urandom));
    repeat (len) begin
      case (pattern)
        0: sample = '0;
        1: begin
          tiny = int'($urandom_range(0, 6)) - 3;
          sample = SAMPLE_W'(tiny);
        end
        2: begin
          mag = mag_aim + int'($urandom_range(0, mag_aim / 8)) - mag_aim / 16;
          if (mag > 32767) mag = 32767;
          sample = $urandom_range(0, 1) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
        end
        3: begin
          case ($urandom_range(0, 2))
            0: sample = 16'h8000;
            1: sample = 16'h7FFF;
            default: sample = 16'h8001;
          endcase
        end
        default: sample = SAMPLE_W'($urandom);
      endcase
      offer_random(OP_TICK, ANGLE_W'($urandom), sample);
    end
  endtask

  // Main stimulus: directed table, then random phases at several register settings.
  initial begin : stimulus
    logic [TICK_W-1:0] phase_targets[5];
    int goal;

    // Directed table; typed results are read off the turn behavior at the register setting in force.
    // Idle ticks after reset.
    dir_table.push_back(item_row(OP_TICK, 9'd0, 16'h0000, 1'b1, {1'b0, 1'b0, 16'd0, 16'd360}));
    dir_table.push_back(item_row(OP_TICK, 9'd511, 16'h8000, 1'b1,
                                 {1'b0, 1'b0, 16'd0, 16'd360}));
    // Start, two ticks at the sample extremes, then restarts with angles 511 and 360, each with a tick.
    dir_table.push_back(item_row(OP_START, 9'd0, 16'h0000, 1'b1, {1'b0, 1'b0, 16'd0, 16'd360}));
    dir_table.push_back(item_row(OP_TICK, 9'd0, 16'h7FFF, 1'b1, {1'b0, 1'b0, 16'd1, 16'd360}));
    dir_table.push_back(item_row(OP_TICK, 9'd0, 16'h8000, 1'b1, {1'b0, 1'b0, 16'd2, 16'd360}));
    dir_table.push_back(item_row(OP_START, 9'd511, 16'hFFFF, 1'b1,
                                 {1'b0, 1'b0, 16'd0, 16'd360}));
    dir_table.push_back(item_row(OP_TICK, 9'd0, 16'hFFFF, 1'b0, '0));
    dir_table.push_back(item_row(OP_START, 9'd360, 16'h0000, 1'b1,
                                 {1'b0, 1'b0, 16'd0, 16'd360}));
    dir_table.push_back(item_row(OP_TICK, 9'd0, 16'h0000, 1'b0, '0));
    // A zero target stops the turn on its first tick; later ticks are idle.
    dir_table.push_back(reg_row(16'd0));
    dir_table.push_back(item_row(OP_START, 9'd45, 16'h0000, 1'b1, {1'b0, 1'b0, 16'd0, 16'd0}));
    dir_table.push_back(item_row(OP_TICK, 9'd0, 16'h0005, 1'b1, {1'b1, 1'b1, 16'd1, 16'd0}));
    dir_table.push_back(item_row(OP_TICK, 9'd0, 16'h0005, 1'b1, {1'b1, 1'b0, 16'd1, 16'd0}));
    dir_table.push_back(item_row(OP_START, 9'd45, 16'h0000, 1'b1, {1'b0, 1'b0, 16'd0, 16'd0}));
    dir_table.push_back(item_row(OP_TICK, 9'd0, 16'h8000, 1'b1, {1'b1, 1'b1, 16'd1, 16'd0}));
    // A small target reached before the measurement.
    dir_table.push_back(reg_row(16'd2));
    dir_table.push_back(item_row(OP_START, 9'd1, 16'h0000, 1'b1, {1'b0, 1'b0, 16'd0, 16'd2}));
    dir_table.push_back(item_row(OP_TICK, 9'd0, 16'h1234, 1'b1, {1'b0, 1'b0, 16'd1, 16'd2}));
    dir_table.push_back(item_row(OP_TICK, 9'd0, 16'h1234, 1'b1, {1'b1, 1'b1, 16'd2, 16'd2}));
    dir_table.push_back(item_row(OP_TICK, 9'd0, 16'h1234, 1'b1, {1'b1, 1'b0, 16'd2, 16'd2}));
    // Largest register value.
    dir_table.push_back(reg_row(16'hFFFF));
    dir_table.push_back(item_row(OP_START, 9'd300, 16'h0000, 1'b1,
                                 {1'b0, 1'b0, 16'd0, 16'hFFFF}));
    dir_table.push_back(item_row(OP_TICK, 9'd0, 16'h0001, 1'b0, '0));

    phase_targets[0] = 16'hFFFF;
    phase_targets[1] = 16'd0;
    phase_targets[2] = TICK_W'($urandom_range(3, 40));
    phase_targets[3] = INIT_TARGET_RESET;
    phase_targets[4] = TICK_W'($urandom);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table.
    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CFG) begin
        drain_results();
        write_init_target(dir_table[i].reg_value);
      end else begin
        offer_row(dir_table[i]);
      end
    end

    // Random phases: mostly whole turns, with some noise transactions between them.
    for (int phase = 0; phase < 5; phase++) begin
      drain_results();
      write_init_target(phase_targets[phase]);
      hold_off_req = (phase == 0);
      no_idle = (phase == 3);
      goal = live_items + PHASE_ITEMS;
      while (live_items < goal) begin
        if ($urandom_range(0, 99) < 85) begin
          run_turn();
        end else begin
          repeat ($urandom_range(1, 4))
            offer_random(1'($urandom), ANGLE_W'($urandom), SAMPLE_W'($urandom));
        end
      end
    end
    no_idle = 1'b0;

    drain_results();
    repeat (END_LATENCY) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
